// File: rtl/lsm_pkg.sv
// Shared types and constants for the longest suffix matcher.
package lsm_pkg;

  localparam int unsigned CHAR_W  = 16;  // wide character
  localparam int unsigned COUNT_W = 5;   // suffix_count register
  localparam int unsigned SLOT_W  = 4;   // table slot field
  localparam int unsigned POS_W   = 3;   // character position field
  localparam int unsigned LEN_W   = 4;   // suffix length field
  localparam int unsigned IDX_W   = 4;   // reported match index
  localparam int unsigned SEEN_W  = 8;   // word character counter

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD_CHAR = 2'd0,
    OP_LOAD_LEN  = 2'd1,
    OP_WORD_CHAR = 2'd2
  } lsm_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_REPORT
  } lsm_state_e;

  // Table load request, raw fields; range checks live in the table.
  typedef struct packed {
    logic              ch_we;
    logic              len_we;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [CHAR_W-1:0] ch;
  } lsm_load_t;

endpackage

// File: rtl/lsm_table.sv
// Suffix table: character memory with registered read and per-entry lengths.
module lsm_table import lsm_pkg::*; #(
  parameter int unsigned MAX_SUFFIXES   = 16,
  parameter int unsigned MAX_SUFFIX_LEN = 8,
  localparam int unsigned SW = (MAX_SUFFIXES > 1) ? $clog2(MAX_SUFFIXES) : 1,
  localparam int unsigned PW = (MAX_SUFFIX_LEN > 1) ? $clog2(MAX_SUFFIX_LEN) : 1,
  localparam int unsigned LW = $clog2(MAX_SUFFIX_LEN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsm_load_t         load_i,
  input  logic              rd_en_i,
  input  logic [SW-1:0]     rd_slot_i,
  input  logic [PW-1:0]     rd_pos_i,
  output logic [CHAR_W-1:0] rd_char_o,
  output logic [LW-1:0]     rd_len_o
);

  logic [CHAR_W-1:0] mem [MAX_SUFFIXES][MAX_SUFFIX_LEN];
  logic [CHAR_W-1:0] rd_char_q;
  logic [LW-1:0]     len_q [MAX_SUFFIXES];

  logic          slot_ok;
  logic          pos_ok;
  logic [SW-1:0] wr_slot;
  logic [PW-1:0] wr_pos;
  logic [LW-1:0] wr_len;

  assign slot_ok = int'(load_i.slot) < MAX_SUFFIXES;
  assign pos_ok  = int'(load_i.pos) < MAX_SUFFIX_LEN;
  assign wr_slot = SW'(load_i.slot);
  assign wr_pos  = PW'(load_i.pos);
  // oversized lengths saturate
  assign wr_len  = (int'(load_i.len) > MAX_SUFFIX_LEN) ? LW'(MAX_SUFFIX_LEN)
                                                       : LW'(load_i.len);

  always_ff @(posedge clk_i) begin
    if (load_i.ch_we && slot_ok && pos_ok) begin
      mem[wr_slot][wr_pos] <= load_i.ch;
    end
    if (rd_en_i) begin
      rd_char_q <= mem[rd_slot_i][rd_pos_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SUFFIXES; i++) begin
        len_q[i] <= '0;
      end
    end else if (load_i.len_we && slot_ok) begin
      len_q[wr_slot] <= wr_len;
    end
  end

  assign rd_char_o = rd_char_q;
  assign rd_len_o  = len_q[rd_slot_i];

endmodule

// File: rtl/longest_suffix_matcher_core.sv
// Top level of the longest suffix matcher: sequencer, match state and result register.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries three kinds of items. Table
//   loads (suffix character, suffix length) are absorbed in the transfer cycle.
//   Word characters are fed from the last character of the word back to the
//   first; the one flagged word_start_i ends the word and yields one result on
//   the output channel (out_valid_o / out_ready_i); other items yield nothing.
//   Write suffix_count (cfg_we_i) only when idle; the block does not check it.
// Timing:
//   A word character walks the n entries in use (n = min(suffix_count,
//   MAX_SUFFIXES)) through one shared compare, one entry per cycle, pipelined
//   behind the table's registered read port. in_ready_o stays low through the
//   scan and finish steps, and also the report step when a result is produced;
//   the result is registered in the report step. Loads keep in_ready_o high.
// Reset: clears the suffix lengths, suffix_count, the sequencer and the per-entry
//   match state; suffix characters hold garbage until loaded.
// Stall: the result sits in an output register, so new items are taken while it
//   waits; a second result waits in the report step until the first is taken.
module longest_suffix_matcher_core import lsm_pkg::*; #(
  parameter int unsigned MAX_SUFFIXES   = 16,
  parameter int unsigned MAX_SUFFIX_LEN = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [SLOT_W-1:0]  suffix_slot_i,
  input  logic [POS_W-1:0]   char_position_i,
  input  logic [LEN_W-1:0]   suffix_length_i,
  input  logic [CHAR_W-1:0]  code_unit_i,
  input  logic               word_start_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [IDX_W-1:0]   match_index_o,
  output logic [LEN_W-1:0]   strip_length_o,
  output logic [SEEN_W-1:0]  kept_length_o
);

  localparam int unsigned SW = (MAX_SUFFIXES > 1) ? $clog2(MAX_SUFFIXES) : 1;
  localparam int unsigned PW = (MAX_SUFFIX_LEN > 1) ? $clog2(MAX_SUFFIX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_SUFFIX_LEN + 1);
  localparam int unsigned CW = $clog2(MAX_SUFFIXES + 1);

  lsm_state_e state_q, state_d;

  logic [COUNT_W-1:0] count_q;
  logic [CW-1:0]      n_used;

  logic               in_fire;
  logic               word_fire;
  lsm_op_e            op;
  lsm_load_t          load;

  // sequencer controls
  logic               issue_a;
  logic               report_fire;

  // word state
  logic [CW-1:0]      j_q;
  logic [CHAR_W-1:0]  ch_q;
  logic               start_q;
  logic [SEEN_W-1:0]  seen_q;
  logic [LW-1:0]      cnt_q [MAX_SUFFIXES];
  logic [MAX_SUFFIXES-1:0] alive_q;

  // stage A: pick entry, read table
  logic [SW-1:0]      idx_a;
  logic [LW-1:0]      cnt_a;
  logic [LW-1:0]      len_a;
  logic               elig_a;
  logic [CHAR_W-1:0]  tbl_char;

  // stage B: compare and update
  logic               b_valid_q;
  logic [SW-1:0]      b_idx_q;
  logic               b_elig_q;
  logic               b_alive_q;
  logic [LW-1:0]      b_cnt_q;
  logic [LW-1:0]      b_len_q;
  logic               hit_b;
  logic [LW-1:0]      new_cnt_b;
  logic               new_alive_b;
  logic               cand_b;

  // running best
  logic [LW-1:0]      best_len_q;
  logic [SW-1:0]      best_idx_q;
  logic               best_found_q;
  logic [SEEN_W-1:0]  best_len_ext;

  // result register
  logic               out_valid_q;
  logic               found_q;
  logic [IDX_W-1:0]   match_index_q;
  logic [LEN_W-1:0]   strip_length_q;
  logic [SEEN_W-1:0]  kept_length_q;

  assign op        = lsm_op_e'(opcode_i);
  assign in_fire   = in_valid_i && in_ready_o;
  assign word_fire = in_fire && (op == OP_WORD_CHAR);

  // entries in use, oversized count clamps
  assign n_used = (int'(count_q) > MAX_SUFFIXES) ? CW'(MAX_SUFFIXES) : CW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // table loads go straight through in the transfer cycle
  always_comb begin
    load        = '0;
    load.slot   = suffix_slot_i;
    load.pos    = char_position_i;
    load.len    = suffix_length_i;
    load.ch     = code_unit_i;
    case (op)
      OP_LOAD_CHAR: load.ch_we  = in_fire;
      OP_LOAD_LEN:  load.len_we = in_fire;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (word_fire) begin
          state_d = (n_used == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((j_q + CW'(1)) == n_used) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = start_q ? ST_REPORT : ST_IDLE;
      ST_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    issue_a     = 1'b0;
    report_fire = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o  = 1'b1;
      ST_SCAN:   issue_a     = 1'b1;
      ST_FINISH: begin
      end
      ST_REPORT: report_fire = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: entry j, eligible if alive and not yet fully matched
  // ---------------------------------------------------------------------------
  assign idx_a  = j_q[SW-1:0];
  assign cnt_a  = cnt_q[idx_a];
  assign elig_a = alive_q[idx_a] && (cnt_a < len_a) && (int'(cnt_a) < MAX_SUFFIX_LEN);

  lsm_table #(
    .MAX_SUFFIXES   (MAX_SUFFIXES),
    .MAX_SUFFIX_LEN (MAX_SUFFIX_LEN)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .rd_en_i   (issue_a && elig_a),
    .rd_slot_i (idx_a),
    .rd_pos_i  (cnt_a[PW-1:0]),
    .rd_char_o (tbl_char),
    .rd_len_o  (len_a)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= issue_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_a) begin
      b_idx_q   <= idx_a;
      b_elig_q  <= elig_a;
      b_alive_q <= alive_q[idx_a];
      b_cnt_q   <= cnt_a;
      b_len_q   <= len_a;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: shared compare, then full-match test against the running best
  // ---------------------------------------------------------------------------
  assign hit_b       = (tbl_char == ch_q);
  assign new_cnt_b   = (b_elig_q && hit_b) ? b_cnt_q + LW'(1) : b_cnt_q;
  assign new_alive_b = b_alive_q && !(b_elig_q && !hit_b);
  assign cand_b      = new_alive_b && (b_len_q != '0) && (new_cnt_b >= b_len_q)
                       && (b_len_q > best_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SUFFIXES; i++) begin
        cnt_q[i] <= '0;
      end
      alive_q <= '1;
      seen_q  <= '0;
    end else if (report_fire) begin
      for (int i = 0; i < MAX_SUFFIXES; i++) begin
        cnt_q[i] <= '0;
      end
      alive_q <= '1;
      seen_q  <= '0;
    end else begin
      if (b_valid_q) begin
        cnt_q[b_idx_q]   <= new_cnt_b;
        alive_q[b_idx_q] <= new_alive_b;
      end
      if (word_fire && (seen_q != SEEN_MAX)) begin
        seen_q <= seen_q + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q          <= '0;
      start_q      <= 1'b0;
      best_found_q <= 1'b0;
    end else if (word_fire) begin
      j_q          <= '0;
      start_q      <= word_start_i;
      best_found_q <= 1'b0;
    end else begin
      if (issue_a) begin
        j_q <= j_q + CW'(1);
      end
      if (b_valid_q && cand_b) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_fire) begin
      ch_q       <= code_unit_i;
      best_len_q <= '0;
      best_idx_q <= '0;
    end else if (b_valid_q && cand_b) begin
      best_len_q <= b_len_q;
      best_idx_q <= b_idx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  assign best_len_ext = SEEN_W'(best_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (report_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (report_fire) begin
      found_q        <= best_found_q;
      match_index_q  <= IDX_W'(best_idx_q);
      strip_length_q <= LEN_W'(best_len_q);
      kept_length_q  <= (best_len_ext > seen_q) ? '0 : seen_q - best_len_ext;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_index_o  = match_index_q;
  assign strip_length_o = strip_length_q;
  assign kept_length_o  = kept_length_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (j_q < n_used))
    else $error("scan index past entries in use");

  a_stage_b_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (state_q == ST_SCAN || state_q == ST_FINISH))
    else $error("compare stage active outside scan");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (match_index_o == '0 && strip_length_o == '0))
    else $error("nonzero index or strip without a match");

  a_word_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_fire |=> (seen_q == '0 && alive_q == '1 && out_valid_q))
    else $error("word state not cleared after report");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_found_q |-> (best_len_q != '0 && int'(best_len_q) <= MAX_SUFFIX_LEN))
    else $error("best match length out of range");

endmodule

// File: tb/suffix_match_checker.sv
`timescale 1ns / 1ps
// Checker for the longest suffix matcher: follows both channels, predicts each word report, compares.
module suffix_match_checker
  import lsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         opcode_i,
  input  logic [SLOT_W-1:0]  suffix_slot_i,
  input  logic [POS_W-1:0]   char_position_i,
  input  logic [LEN_W-1:0]   suffix_length_i,
  input  logic [CHAR_W-1:0]  code_unit_i,
  input  logic               word_start_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               found_i,
  input  logic [IDX_W-1:0]   match_index_i,
  input  logic [LEN_W-1:0]   strip_length_i,
  input  logic [SEEN_W-1:0]  kept_length_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned SUFFIX_MAX  = 8;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [LEN_W-1:0]  strip_length;
    logic [SEEN_W-1:0] kept_length;
  } stem_report_t;

  // predicted suffix table and per-word match state
  logic [CHAR_W-1:0]      tbl_char [TABLE_DEPTH][SUFFIX_MAX];
  logic [LEN_W-1:0]       tbl_len  [TABLE_DEPTH];
  logic [LEN_W-1:0]       hit_cnt  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] alive_mask;
  logic [SEEN_W-1:0]      chars_seen;
  logic [COUNT_W-1:0]     entries_cfg;

  stem_report_t expected_reports [$];
  int unsigned  mismatches;

  task automatic clear_word();
    int unsigned j;
    for (j = 0; j < TABLE_DEPTH; j++) begin
      hit_cnt[j] = '0;
    end
    alive_mask = '1;
    chars_seen = '0;
  endtask

  task automatic advance_matcher();
    int unsigned  live, j, cnt, best_len, best_idx;
    logic         hit;
    stem_report_t rep;
    live = (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : entries_cfg;
    case (opcode_i)
      OP_LOAD_CHAR: tbl_char[suffix_slot_i][char_position_i] = code_unit_i;
      OP_LOAD_LEN: begin
        tbl_len[suffix_slot_i] = (suffix_length_i > SUFFIX_MAX) ? LEN_W'(SUFFIX_MAX)
                                                                : suffix_length_i;
      end
      OP_WORD_CHAR: begin
        for (j = 0; j < live; j++) begin
          cnt = hit_cnt[j];
          if (alive_mask[j] && cnt < tbl_len[j] && cnt < SUFFIX_MAX) begin
            if (tbl_char[j][cnt] == code_unit_i) begin
              hit_cnt[j] = LEN_W'(cnt + 1);
            end else begin
              alive_mask[j] = 1'b0;
            end
          end
        end
        if (chars_seen != SEEN_MAX) begin
          chars_seen = chars_seen + 1'b1;
        end
        if (word_start_i) begin
          best_len = 0;
          best_idx = 0;
          hit      = 1'b0;
          for (j = 0; j < live; j++) begin
            if (alive_mask[j] && tbl_len[j] > 0 && hit_cnt[j] >= tbl_len[j] &&
                tbl_len[j] > best_len) begin
              best_len = tbl_len[j];
              best_idx = j;
              hit      = 1'b1;
            end
          end
          rep.found        = hit;
          rep.match_index  = IDX_W'(best_idx);
          rep.strip_length = LEN_W'(best_len);
          rep.kept_length  = (best_len > chars_seen) ? '0 : SEEN_W'(chars_seen - best_len);
          expected_reports.push_back(rep);
          clear_word();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_report();
    stem_report_t want;
    if (expected_reports.size() == 0) begin
      $error("unexpected report: found %0d match_index %0d strip_length %0d kept_length %0d",
             found_i, match_index_i, strip_length_i, kept_length_i);
      mismatches++;
    end else begin
      want = expected_reports.pop_front();
      if (found_i !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found_i);
        mismatches++;
      end
      if (match_index_i !== want.match_index) begin
        $error("match_index: expected %0d, got %0d", want.match_index, match_index_i);
        mismatches++;
      end
      if (strip_length_i !== want.strip_length) begin
        $error("strip_length: expected %0d, got %0d", want.strip_length, strip_length_i);
        mismatches++;
      end
      if (kept_length_i !== want.kept_length) begin
        $error("kept_length: expected %0d, got %0d", want.kept_length, kept_length_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        tbl_len[j] = '0;
      end
      clear_word();
      entries_cfg = '0;
      expected_reports.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_report();
      end
      if (cfg_we_i) begin
        entries_cfg = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        advance_matcher();
      end
      pending_o    <= expected_reports.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/tb_longest_suffix_matcher_core.sv
`timescale 1ns / 1ps
// Testbench top for longest_suffix_matcher_core: stimulus, flow control and verdict.
module tb_longest_suffix_matcher_core;
  import lsm_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned SUFFIX_MAX    = 8;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;   // spare opcode, dropped by the block
  localparam int unsigned ITEM_TARGET   = 1550;
  localparam int unsigned SETTLE_CYCLES = 24;     // covers the walk over all 16 entries
  localparam int unsigned HOLD_CYCLES   = 300;    // long receiver back-pressure
  localparam int unsigned CYCLE_LIMIT   = 600000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode    = '0;
  logic [SLOT_W-1:0]  slot      = '0;
  logic [POS_W-1:0]   position  = '0;
  logic [LEN_W-1:0]   length    = '0;
  logic [CHAR_W-1:0]  code_unit = '0;
  logic               word_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [IDX_W-1:0]   match_index;
  logic [LEN_W-1:0]   strip_length;
  logic [SEEN_W-1:0]  kept_length;
  int unsigned        pending;
  int unsigned        fail_count;

  // Shadow of the suffix table as the stimulus has loaded it. It is used to
  // build words that actually end in a loaded suffix, and to keep every
  // length load within the prefix of characters already written, so that
  // the block never compares against a table character that was never set.
  logic [CHAR_W-1:0]     shadow_char    [TABLE_DEPTH][SUFFIX_MAX];
  logic [SUFFIX_MAX-1:0] shadow_written [TABLE_DEPTH];
  int unsigned           shadow_len     [TABLE_DEPTH];
  int unsigned           live_entries;
  logic [CHAR_W-1:0]     word_buf [$];    // word in feed order, last character first

  bit          sender_quiet;
  int unsigned items_sent, load_count, word_chars, words_done, settings_used;
  int unsigned results_taken, cycles;

  longest_suffix_matcher_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .suffix_slot_i   (slot),
    .char_position_i (position),
    .suffix_length_i (length),
    .code_unit_i     (code_unit),
    .word_start_i    (word_start),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .found_o         (found),
    .match_index_o   (match_index),
    .strip_length_o  (strip_length),
    .kept_length_o   (kept_length)
  );

  suffix_match_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .suffix_slot_i   (slot),
    .char_position_i (position),
    .suffix_length_i (length),
    .code_unit_i     (code_unit),
    .word_start_i    (word_start),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .found_i         (found),
    .match_index_i   (match_index),
    .strip_length_i  (strip_length),
    .kept_length_i   (kept_length),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall before each result, stretches without stalls, and
  // two long hold-offs while the sender keeps going, so the output register
  // and the report step fill up and in_ready drops.
  initial begin : result_sink
    int unsigned stall;
    results_taken = 0;
    forever begin
      if (results_taken == 10 || results_taken == 120) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = ((results_taken / 25) % 4 == 1) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  // One input transfer. Valid stays up across back-to-back items and is
  // only dropped when a gap is drawn, so it never sees two updates in a step.
  task automatic push_item(input logic [1:0] op, input logic [SLOT_W-1:0] s,
                           input logic [POS_W-1:0] p, input logic [LEN_W-1:0] l,
                           input logic [CHAR_W-1:0] c, input logic ws);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    slot       <= s;
    position   <= p;
    length     <= l;
    code_unit  <= c;
    word_start <= ws;
    do @(posedge clk); while (!in_ready);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  // Fields a given opcode does not use are driven with random values.
  task automatic load_char(input int unsigned s, input int unsigned p, input logic [CHAR_W-1:0] c);
    push_item(OP_LOAD_CHAR, SLOT_W'(s), POS_W'(p), LEN_W'($urandom), c, 1'($urandom));
    shadow_char[s][p]    = c;
    shadow_written[s][p] = 1'b1;
    load_count++;
  endtask

  task automatic load_len(input int unsigned s, input int unsigned l);
    push_item(OP_LOAD_LEN, SLOT_W'(s), POS_W'($urandom), LEN_W'(l), CHAR_W'($urandom),
              1'($urandom));
    shadow_len[s] = (l > SUFFIX_MAX) ? SUFFIX_MAX : l;
    load_count++;
  endtask

  task automatic feed_char(input logic [CHAR_W-1:0] c, input logic ws);
    push_item(OP_WORD_CHAR, SLOT_W'($urandom), POS_W'($urandom), LEN_W'($urandom), c, ws);
    word_chars++;
    if (ws) begin
      words_done++;
    end
  endtask

  // Number of leading suffix positions (from the end) already written.
  function automatic int unsigned written_prefix(input int unsigned s);
    int unsigned p;
    p = 0;
    while (p < SUFFIX_MAX && shadow_written[s][p]) begin
      p++;
    end
    return p;
  endfunction

  // Mostly a three-letter alphabet so suffixes overlap; the rest hits every bit.
  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(0, 9))
      0: return CHAR_W'($urandom);
      1: return '1;
      2: return '0;
      default: return CHAR_W'(16'h0061 + $urandom_range(0, 2));
    endcase
  endfunction

  // Drain: drop valid, wait for every report, let the block finish its walk.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_suffix_count(input int unsigned n);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    live_entries = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    settings_used++;
  endtask

  // Fresh suffix of random length; zero gives a never-matching entry, and a
  // full-length one sometimes gets an oversized length value.
  task automatic rewrite_slot(input int unsigned s);
    int unsigned ln, p;
    ln = $urandom_range(0, SUFFIX_MAX);
    for (p = 0; p < ln; p++) begin
      load_char(s, p, pick_char());
    end
    if (ln == SUFFIX_MAX && $urandom_range(0, 2) == 0) begin
      load_len(s, $urandom_range(SUFFIX_MAX + 1, 15));
    end else begin
      load_len(s, ln);
    end
  endtask

  // Table edits dropped in between or inside words, plus the spare opcode.
  task automatic table_noise();
    int unsigned s, w;
    s = $urandom_range(0, TABLE_DEPTH - 1);
    case ($urandom_range(0, 2))
      0: load_char(s, $urandom_range(0, SUFFIX_MAX - 1), pick_char());
      1: begin
        w = written_prefix(s);
        load_len(s, (w == SUFFIX_MAX) ? $urandom_range(0, 15) : $urandom_range(0, w));
      end
      default: begin
        push_item(OP_UNUSED, SLOT_W'($urandom), POS_W'($urandom), LEN_W'($urandom),
                  CHAR_W'($urandom), 1'($urandom));
      end
    endcase
  endtask

  task automatic send_word();
    int unsigned p;
    for (p = 0; p < word_buf.size(); p++) begin
      if ($urandom_range(0, 39) == 0) begin
        table_noise();
      end
      feed_char(word_buf[p], p == word_buf.size() - 1);
    end
    word_buf.delete();
  endtask

  // Most words end in a live table suffix; some have one character flipped,
  // some are shorter than the suffix, the rest are plain noise.
  task automatic random_word(input bit long_word);
    int unsigned cand [TABLE_DEPTH];
    int unsigned n_cand, kind, j, p, take, extras;
    n_cand = 0;
    for (j = 0; j < live_entries; j++) begin
      if (shadow_len[j] > 0) begin
        cand[n_cand] = j;
        n_cand++;
      end
    end
    kind   = $urandom_range(0, 9);
    extras = $urandom_range(1, 6);
    if (n_cand > 0 && kind < 8) begin
      j      = cand[$urandom_range(0, n_cand - 1)];
      take   = shadow_len[j];
      extras = $urandom_range(0, 4);
      if (kind == 7 && take > 1) begin
        take   = $urandom_range(1, take - 1);
        extras = 0;
      end
      for (p = 0; p < take; p++) begin
        word_buf.push_back(shadow_char[j][p]);
      end
      if (kind == 6) begin
        p = $urandom_range(0, take - 1);
        word_buf[p] = ~word_buf[p];
      end
    end
    // long enough to saturate the word counter
    if (long_word) begin
      extras = 256 + $urandom_range(0, 10);
    end
    repeat (extras) word_buf.push_back(pick_char());
    send_word();
  endtask

  initial begin : stimulus
    int unsigned j, phase, n, w;
    for (j = 0; j < TABLE_DEPTH; j++) begin
      shadow_written[j] = '0;
      shadow_len[j]     = 0;
    end
    live_entries  = 0;
    sender_quiet  = 1'b0;
    items_sent    = 0;
    load_count    = 0;
    word_chars    = 0;
    words_done    = 0;
    settings_used = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    feed_char('1, 1'b1);                              // empty table: no match, kept 1
    push_item(OP_UNUSED, '1, '1, '1, '1, 1'b1);       // spare opcode, all fields high
    load_char(0, 0, '0);
    load_char(0, 1, '1);
    load_len(0, 2);
    load_char(1, 0, '0);
    load_len(1, 1);
    load_char(2, 0, '0);                              // same suffix as slot 0: tie
    load_char(2, 1, '1);
    load_len(2, 2);
    load_len(3, 0);                                   // zero-length entry
    set_suffix_count(4);
    word_buf = '{'0, '1, 16'h1234};                   // tie on length 2, slot 0 wins
    send_word();
    feed_char('0, 1'b1);                              // slot 0 longer than the word
    feed_char('0, 1'b0);                              // shrink entries mid-word
    feed_char('1, 1'b0);
    load_len(0, 1);
    load_len(2, 1);
    feed_char(16'h1234, 1'b1);
    feed_char(16'h0042, 1'b1);                        // nothing matches

    // --- random phases, each under its own suffix_count ---
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 6)
        0: n = 16;
        1: n = 31;
        2: n = $urandom_range(1, 15);
        3: n = 0;
        4: n = $urandom_range(17, 30);
        default: n = $urandom_range(0, 31);
      endcase
      set_suffix_count(n);
      sender_quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        rewrite_slot((live_entries > 0 && $urandom_range(0, 4) != 0) ?
                     $urandom_range(0, live_entries - 1) : $urandom_range(0, TABLE_DEPTH - 1));
      end
      for (w = 0; w < 8; w++) begin
        random_word(phase == 6 && w == 0);
        if ($urandom_range(0, 5) == 0) begin
          table_noise();
        end
      end
      phase++;
    end

    wait_idle();
    $display("Covered %0d table loads and %0d word characters in %0d words, %0d count settings.",
             load_count, word_chars, words_done, settings_used);
    $display("Included idle gaps, %0d-cycle output hold-offs and the saturating word counter.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
